// ----- design/rwrp_pkg.sv -----
// ----------------------------------------------------------------------------
// rwrp_pkg
// Shared types and codes for the read/write registers response parser.
// ----------------------------------------------------------------------------
package rwrp_pkg;

  localparam logic [7:0] FN_RW_REGS  = 8'h17;
  localparam logic [7:0] FN_EXC_FLAG = 8'h80;

  localparam logic [2:0] EV_START = 3'd0;
  localparam logic [2:0] EV_VALUE = 3'd1;
  localparam logic [2:0] EV_END   = 3'd2;
  localparam logic [2:0] EV_EXC   = 3'd3;
  localparam logic [2:0] EV_ERROR = 3'd4;

  localparam logic [2:0] ERR_NONE  = 3'd0;
  localparam logic [2:0] ERR_SLAVE = 3'd1;
  localparam logic [2:0] ERR_TRUNC = 3'd2;
  localparam logic [2:0] ERR_COUNT = 3'd3;
  localparam logic [2:0] ERR_FUNC  = 3'd4;

  localparam logic [1:0] CFG_EXPECTED_SLAVE = 2'd0;
  localparam logic [1:0] CFG_READ_START     = 2'd1;
  localparam logic [1:0] CFG_READ_QUANTITY  = 2'd2;

  localparam int RES_DEPTH = 4;
  localparam int RES_AW    = 2;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] reg_address;
    logic [15:0] reg_value;
    logic [2:0]  error_code;
    logic        run_last;
  } result_t;

endpackage

// ----- design/rw_registers_response_parser_core.sv -----
// ----------------------------------------------------------------------------
// rw_registers_response_parser_core
// Parses a function 0x17 response byte by byte into start, value, end,
// exception and error events.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | frame_byte, frame_end
//   out_    | output    | out_valid / out_ready | one event per transfer
//   cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// A byte is parsed in the cycle it is taken; its zero, one or two events
// enter a four-entry result queue and appear from the next cycle.
// One byte per cycle is taken while the queue holds at most two events.
// Bytes that cause two events slow input only when the sink stalls.
// Synchronous reset clears parse state and queue, and sets slave 1, start 0, quantity 1.
// ----------------------------------------------------------------------------
module rw_registers_response_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_kind,
  output logic [15:0] out_reg_address,
  output logic [15:0] out_reg_value,
  output logic [2:0]  out_error_code,
  output logic        out_run_last
);
  import rwrp_pkg::*;

  typedef enum logic [2:0] {
    PH_ADDR, PH_FUNC, PH_COUNT, PH_HIGH, PH_LOW, PH_EXC, PH_DROP
  } phase_t;

  logic [7:0]  expected_slave_r;
  logic [15:0] read_start_address_r;
  logic [6:0]  read_quantity_r;

  phase_t      phase_r, phase_nxt;
  logic [6:0]  regs_left_r, regs_left_nxt;
  logic [15:0] cur_addr_r, cur_addr_nxt;
  logic [7:0]  hold_r, hold_nxt;

  result_t     res0, res1;
  logic [1:0]  n_res;

  result_t     q_mem [RES_DEPTH];
  logic [RES_AW-1:0] wptr_r, rptr_r;
  logic [RES_AW:0]   count_r, count_nxt;

  logic        in_xfer, out_xfer;
  logic [6:0]  regs_dec;
  phase_t      finish_ph;

  assign in_ready  = (count_r <= (RES_AW+1)'(RES_DEPTH - 2));
  assign out_valid = (count_r != '0);
  assign in_xfer   = in_valid & in_ready;
  assign out_xfer  = out_valid & out_ready;
  assign regs_dec  = regs_left_r - 7'd1;
  assign finish_ph = in_frame_end ? PH_ADDR : PH_DROP;

  function automatic result_t mk_res(logic [2:0] kind, logic [15:0] addr,
                                     logic [15:0] value, logic [2:0] err);
    result_t r;
    r.event_kind  = kind;
    r.reg_address = addr;
    r.reg_value   = value;
    r.error_code  = err;
    r.run_last    = 1'b0;
    return r;
  endfunction

  always_comb begin
    phase_nxt     = phase_r;
    regs_left_nxt = regs_left_r;
    cur_addr_nxt  = cur_addr_r;
    hold_nxt      = hold_r;
    res0          = mk_res(EV_ERROR, '0, '0, ERR_NONE);
    res1          = mk_res(EV_ERROR, '0, '0, ERR_NONE);
    n_res         = 2'd0;
    case (phase_r)
      PH_ADDR: begin
        if (in_frame_byte != expected_slave_r) begin
          res0 = mk_res(EV_ERROR, '0, '0, ERR_SLAVE);
          n_res = 2'd1;
          phase_nxt = finish_ph;
        end else if (in_frame_end) begin
          res0 = mk_res(EV_ERROR, '0, '0, ERR_TRUNC);
          n_res = 2'd1;
          phase_nxt = finish_ph;
        end else begin
          phase_nxt = PH_FUNC;
        end
      end
      PH_FUNC: begin
        if (in_frame_byte == FN_RW_REGS || in_frame_byte == (FN_RW_REGS | FN_EXC_FLAG)) begin
          if (in_frame_end) begin
            res0 = mk_res(EV_ERROR, '0, '0, ERR_TRUNC);
            n_res = 2'd1;
            phase_nxt = finish_ph;
          end else begin
            phase_nxt = (in_frame_byte == FN_RW_REGS) ? PH_COUNT : PH_EXC;
          end
        end else begin
          res0 = mk_res(EV_ERROR, '0, '0, ERR_FUNC);
          n_res = 2'd1;
          phase_nxt = finish_ph;
        end
      end
      PH_COUNT: begin
        if (in_frame_byte != {read_quantity_r, 1'b0}) begin
          res0 = mk_res(EV_ERROR, '0, '0, ERR_COUNT);
          n_res = 2'd1;
          phase_nxt = finish_ph;
        end else begin
          res0 = mk_res(EV_START, '0, '0, ERR_NONE);
          n_res = 2'd1;
          regs_left_nxt = read_quantity_r;
          cur_addr_nxt  = read_start_address_r;
          if (read_quantity_r == '0) begin
            res1 = mk_res(EV_END, '0, '0, ERR_NONE);
            n_res = 2'd2;
            phase_nxt = finish_ph;
          end else if (in_frame_end) begin
            res1 = mk_res(EV_ERROR, '0, '0, ERR_TRUNC);
            n_res = 2'd2;
            phase_nxt = finish_ph;
          end else begin
            phase_nxt = PH_HIGH;
          end
        end
      end
      PH_HIGH: begin
        hold_nxt = in_frame_byte;
        if (in_frame_end) begin
          res0 = mk_res(EV_ERROR, '0, '0, ERR_TRUNC);
          n_res = 2'd1;
          phase_nxt = finish_ph;
        end else begin
          phase_nxt = PH_LOW;
        end
      end
      PH_LOW: begin
        res0 = mk_res(EV_VALUE, cur_addr_r, {hold_r, in_frame_byte}, ERR_NONE);
        n_res = 2'd1;
        cur_addr_nxt  = cur_addr_r + 16'd1;
        regs_left_nxt = regs_dec;
        if (regs_dec == '0) begin
          res1 = mk_res(EV_END, '0, '0, ERR_NONE);
          n_res = 2'd2;
          phase_nxt = finish_ph;
        end else if (in_frame_end) begin
          res1 = mk_res(EV_ERROR, '0, '0, ERR_TRUNC);
          n_res = 2'd2;
          phase_nxt = finish_ph;
        end else begin
          phase_nxt = PH_HIGH;
        end
      end
      PH_EXC: begin
        res0 = mk_res(EV_EXC, '0, {8'h00, in_frame_byte}, ERR_NONE);
        n_res = 2'd1;
        phase_nxt = finish_ph;
      end
      default: begin
        if (in_frame_end) begin
          phase_nxt = PH_ADDR;
        end
      end
    endcase
    if (n_res == 2'd2) begin
      res1.run_last = 1'b1;
    end else begin
      res0.run_last = 1'b1;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (in_xfer) begin
      count_nxt = count_nxt + (RES_AW+1)'(n_res);
    end
    if (out_xfer) begin
      count_nxt = count_nxt - (RES_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_slave_r     <= 8'd1;
      read_start_address_r <= 16'd0;
      read_quantity_r      <= 7'd1;
      phase_r              <= PH_ADDR;
      regs_left_r          <= '0;
      cur_addr_r           <= '0;
      hold_r               <= '0;
      wptr_r               <= '0;
      rptr_r               <= '0;
      count_r              <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_EXPECTED_SLAVE: expected_slave_r     <= cfg_wdata[7:0];
          CFG_READ_START:     read_start_address_r <= cfg_wdata;
          CFG_READ_QUANTITY:  read_quantity_r      <= cfg_wdata[6:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        phase_r     <= phase_nxt;
        regs_left_r <= regs_left_nxt;
        cur_addr_r  <= cur_addr_nxt;
        hold_r      <= hold_nxt;
        wptr_r      <= wptr_r + RES_AW'(n_res);
      end
      if (out_xfer) begin
        rptr_r <= rptr_r + RES_AW'(1);
      end
      count_r <= count_nxt;
    end
  end

  // hold results until transfer
  always_ff @(posedge clk) begin
    if (in_xfer && n_res != 2'd0) begin
      q_mem[wptr_r] <= res0;
    end
    if (in_xfer && n_res == 2'd2) begin
      q_mem[wptr_r + RES_AW'(1)] <= res1;
    end
  end

  assign out_event_kind  = q_mem[rptr_r].event_kind;
  assign out_reg_address = q_mem[rptr_r].reg_address;
  assign out_reg_value   = q_mem[rptr_r].reg_value;
  assign out_error_code  = q_mem[rptr_r].error_code;
  assign out_run_last    = q_mem[rptr_r].run_last;

endmodule

// ----- design/rwrp_checker.sv -----
// ----------------------------------------------------------------------------
// rwrp_checker
// Port-level checks for the read/write registers response parser.
// ----------------------------------------------------------------------------
module rwrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_kind,
  input logic [15:0] out_reg_address,
  input logic [15:0] out_reg_value,
  input logic [2:0]  out_error_code,
  input logic        out_run_last
);
  import rwrp_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_kind)
      && $stable(out_reg_value) && $stable(out_run_last))
    else $error("stalled result changed");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_event_kind == EV_ERROR) == (out_error_code != ERR_NONE)))
    else $error("error code does not match event kind");

  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind != EV_VALUE |-> out_reg_address == '0)
    else $error("address on non-value event");

  a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == EV_START && !out_run_last && out_ready
      |=> out_valid && (out_event_kind == EV_END || out_event_kind == EV_ERROR))
    else $error("start event not followed by its partner");

  a_reset_ready: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> in_ready && !out_valid)
    else $error("not empty after reset");

endmodule

bind rw_registers_response_parser_core rwrp_checker u_rwrp_checker (.*);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the read/write registers response parser.
// Response frames go in one byte per transfer: first a short table of directed
// bytes, then ten register settings that include the extremes, each with
// random frames. Most frames are well formed. The rest are truncated, come
// from a wrong slave, or carry a bad function code or byte count. A parser
// model built into the bench predicts all but typed directed events, and each
// transfer is checked field by field against the oldest expectation. The
// sender idles in bursts and the sink stalls in several patterns of its own.
// ----------------------------------------------------------------------------
module tb_top;
  import rwrp_pkg::*;

  typedef enum logic [2:0] {
    WAIT_ADDR, WAIT_FUNC, WAIT_COUNT, WAIT_HIGH, WAIT_LOW, WAIT_EXC, DROP_REST
  } parse_phase_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_LONG} rx_mode_t;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       fend;
    logic       typed;
    logic [2:0] kind;
    logic [2:0] err;
  } directed_row_t;

  localparam int  N_DIRECTED      = 28;
  localparam int  PHASE_BYTES     = 70;
  localparam int  N_RANDOM_PHASES = 10;
  localparam int  MAX_REPORTS     = 30;
  localparam bit  TYPED           = 1'b1;
  localparam bit  PREDICTED       = 1'b0;

  logic        clk           = 1'b0;
  logic        rst_n         = 1'b0;
  logic        cfg_we        = 1'b0;
  logic [1:0]  cfg_index     = CFG_EXPECTED_SLAVE;
  logic [15:0] cfg_wdata     = 16'h0000;
  logic        in_valid      = 1'b0;
  logic        in_ready;
  logic [7:0]  in_frame_byte = 8'h00;
  logic        in_frame_end  = 1'b0;
  logic        out_valid;
  logic        out_ready     = 1'b0;
  logic [2:0]  out_event_kind;
  logic [15:0] out_reg_address;
  logic [15:0] out_reg_value;
  logic [2:0]  out_error_code;
  logic        out_run_last;

  rw_registers_response_parser_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_frame_byte   (in_frame_byte),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_event_kind  (out_event_kind),
    .out_reg_address (out_reg_address),
    .out_reg_value   (out_reg_value),
    .out_error_code  (out_error_code),
    .out_run_last    (out_run_last)
  );

  // parser model state and its copy of the registers
  logic [7:0]   slave_reg  = 8'd1;
  logic [15:0]  start_reg  = 16'd0;
  logic [6:0]   qty_reg    = 7'd1;
  parse_phase_t phase      = WAIT_ADDR;
  logic [6:0]   regs_left  = 7'd0;
  logic [15:0]  cur_addr   = 16'd0;
  logic [7:0]   high_hold  = 8'd0;

  result_t new_events[$];
  result_t expected_events[$];

  int errors         = 0;
  int bytes_sent     = 0;
  int frames_sent    = 0;
  int settings_used  = 1;
  int events_checked = 0;
  int values_checked = 0;
  int burst_left     = 0;

  rx_mode_t rx_mode    = RX_OPEN;
  int       mode_left  = 0;
  int       stall_left = 0;
  int       tick       = 0;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{8'h00, 1'b0, TYPED,     EV_ERROR, ERR_SLAVE},
    '{8'hFF, 1'b1, PREDICTED, EV_START, ERR_NONE},
    '{8'h01, 1'b1, TYPED,     EV_ERROR, ERR_TRUNC},
    '{8'h01, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h03, 1'b0, TYPED,     EV_ERROR, ERR_FUNC},
    '{8'h55, 1'b1, PREDICTED, EV_START, ERR_NONE},
    '{8'h01, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h17, 1'b1, TYPED,     EV_ERROR, ERR_TRUNC},
    '{8'h01, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h97, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h02, 1'b1, PREDICTED, EV_START, ERR_NONE},
    '{8'h01, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h17, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h04, 1'b0, TYPED,     EV_ERROR, ERR_COUNT},
    '{8'h00, 1'b1, PREDICTED, EV_START, ERR_NONE},
    '{8'h01, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h17, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h02, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'hFF, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'hFF, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'hAA, 1'b1, PREDICTED, EV_START, ERR_NONE},
    '{8'h01, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h17, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h02, 1'b1, PREDICTED, EV_START, ERR_NONE},
    '{8'h01, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h17, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h02, 1'b0, PREDICTED, EV_START, ERR_NONE},
    '{8'h00, 1'b1, PREDICTED, EV_START, ERR_NONE}
  };

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("rw_registers_response_parser_core verification failed");
    $finish;
  end

  function automatic result_t make_event(input logic [2:0] kind, input logic [15:0] addr,
                                         input logic [15:0] value, input logic [2:0] err);
    result_t ev;
    ev.event_kind  = kind;
    ev.reg_address = addr;
    ev.reg_value   = value;
    ev.error_code  = err;
    ev.run_last    = 1'b0;
    return ev;
  endfunction

  // advance the parser model by one byte; its events land in new_events
  function automatic void parse_byte(input logic [7:0] b, input logic e);
    logic done;
    done = 1'b0;
    new_events.delete();
    case (phase)
      WAIT_ADDR: begin
        if (b != slave_reg) begin
          new_events.push_back(make_event(EV_ERROR, 16'h0, 16'h0, ERR_SLAVE));
          done = 1'b1;
        end else if (e) begin
          new_events.push_back(make_event(EV_ERROR, 16'h0, 16'h0, ERR_TRUNC));
          done = 1'b1;
        end else begin
          phase = WAIT_FUNC;
        end
      end
      WAIT_FUNC: begin
        if (b == FN_RW_REGS || b == (FN_RW_REGS | FN_EXC_FLAG)) begin
          if (e) begin
            new_events.push_back(make_event(EV_ERROR, 16'h0, 16'h0, ERR_TRUNC));
            done = 1'b1;
          end else begin
            phase = (b == FN_RW_REGS) ? WAIT_COUNT : WAIT_EXC;
          end
        end else begin
          new_events.push_back(make_event(EV_ERROR, 16'h0, 16'h0, ERR_FUNC));
          done = 1'b1;
        end
      end
      WAIT_COUNT: begin
        if (b != {qty_reg, 1'b0}) begin
          new_events.push_back(make_event(EV_ERROR, 16'h0, 16'h0, ERR_COUNT));
          done = 1'b1;
        end else begin
          new_events.push_back(make_event(EV_START, 16'h0, 16'h0, ERR_NONE));
          regs_left = qty_reg;
          cur_addr  = start_reg;
          if (regs_left == 7'd0) begin
            new_events.push_back(make_event(EV_END, 16'h0, 16'h0, ERR_NONE));
            done = 1'b1;
          end else if (e) begin
            new_events.push_back(make_event(EV_ERROR, 16'h0, 16'h0, ERR_TRUNC));
            done = 1'b1;
          end else begin
            phase = WAIT_HIGH;
          end
        end
      end
      WAIT_HIGH: begin
        high_hold = b;
        if (e) begin
          new_events.push_back(make_event(EV_ERROR, 16'h0, 16'h0, ERR_TRUNC));
          done = 1'b1;
        end else begin
          phase = WAIT_LOW;
        end
      end
      WAIT_LOW: begin
        new_events.push_back(make_event(EV_VALUE, cur_addr, {high_hold, b}, ERR_NONE));
        cur_addr  = cur_addr + 16'd1;
        regs_left = regs_left - 7'd1;
        if (regs_left == 7'd0) begin
          new_events.push_back(make_event(EV_END, 16'h0, 16'h0, ERR_NONE));
          done = 1'b1;
        end else if (e) begin
          new_events.push_back(make_event(EV_ERROR, 16'h0, 16'h0, ERR_TRUNC));
          done = 1'b1;
        end else begin
          phase = WAIT_HIGH;
        end
      end
      WAIT_EXC: begin
        new_events.push_back(make_event(EV_EXC, 16'h0, {8'h00, b}, ERR_NONE));
        done = 1'b1;
      end
      default: begin
        if (e) begin
          phase = WAIT_ADDR;
        end
      end
    endcase
    if (done) begin
      phase = e ? WAIT_ADDR : DROP_REST;
    end
    if (new_events.size() > 0) begin
      new_events[new_events.size() - 1].run_last = 1'b1;
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      end
    end
  endtask

  task automatic check_event();
    result_t exp_ev;
    events_checked++;
    if (out_event_kind == EV_VALUE) begin
      values_checked++;
    end
    if (expected_events.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: unexpected event, expected none, got kind %0d code %0d", $time,
                 out_event_kind, out_error_code);
      end
    end else begin
      exp_ev = expected_events.pop_front();
      compare_field("event_kind", 16'(exp_ev.event_kind), 16'(out_event_kind));
      compare_field("reg_address", exp_ev.reg_address, out_reg_address);
      compare_field("reg_value", exp_ev.reg_value, out_reg_value);
      compare_field("error_code", 16'(exp_ev.error_code), 16'(out_error_code));
      compare_field("run_last", 16'(exp_ev.run_last), 16'(out_run_last));
    end
  endtask

  // sink: check each event transfer, then pick next cycle's ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_event();
      end
      if (mode_left == 0) begin
        rx_mode   = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      tick++;
      case (rx_mode)
        RX_OPEN:    out_ready <= 1'b1;
        RX_RANDOM:  out_ready <= ($urandom_range(0, 3) != 0);
        RX_PATTERN: out_ready <= ((tick % 5) < 3);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0) begin
              stall_left = $urandom_range(1, 10);
            end
          end
        end
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic e, input logic typed,
                           input result_t typed_ev);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                               : $urandom_range(1, 12);
    end
    in_valid      <= 1'b1;
    in_frame_byte <= b;
    in_frame_end  <= e;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    bytes_sent++;
    parse_byte(b, e);
    if (typed) begin
      expected_events.push_back(typed_ev);
    end else begin
      foreach (new_events[i]) expected_events.push_back(new_events[i]);
    end
  endtask

  task automatic send_frame();
    logic [7:0] fb[$];
    int         sel;
    int         end_pos;
    int         n_data;
    logic       is_exc;
    logic       cut;
    sel    = $urandom_range(0, 99);
    is_exc = (sel >= 50 && sel < 60) || (sel >= 70 && sel < 75);
    cut    = (sel >= 60 && sel < 75);
    fb.push_back(slave_reg);
    if (sel >= 75 && sel < 85) begin
      fb[0] = slave_reg ^ 8'($urandom_range(1, 255));
    end
    if (sel >= 85 && sel < 93) begin
      fb.push_back(rand_byte());
    end else begin
      fb.push_back(is_exc ? (FN_RW_REGS | FN_EXC_FLAG) : FN_RW_REGS);
    end
    if (is_exc) begin
      fb.push_back(rand_byte());
    end else begin
      fb.push_back((sel >= 93) ? rand_byte() : {qty_reg, 1'b0});
      n_data = (sel >= 85) ? $urandom_range(0, 6) : 2 * qty_reg;
      repeat (n_data) fb.push_back(rand_byte());
    end
    if (cut) begin
      end_pos = $urandom_range(0, fb.size() - 2);
    end else begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) fb.push_back(rand_byte());
      end
      end_pos = fb.size() - 1;
    end
    for (int i = 0; i <= end_pos; i++) begin
      send_byte(fb[i], i == end_pos, PREDICTED, '0);
    end
    frames_sent++;
  endtask

  // hold input, drain every expected event, let the parser go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [7:0] s, input logic [15:0] st, input logic [6:0] q);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EXPECTED_SLAVE;
    cfg_wdata <= {8'h00, s};
    @(posedge clk);
    slave_reg = s;
    cfg_index <= CFG_READ_START;
    cfg_wdata <= st;
    @(posedge clk);
    start_reg = st;
    cfg_index <= CFG_READ_QUANTITY;
    cfg_wdata <= {9'h000, q};
    @(posedge clk);
    qty_reg = q;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    result_t    ev;
    logic [7:0] s;
    logic [15:0] st;
    logic [6:0] q;
    int         phase_start;
    int         guard;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      ev = make_event(directed_rows[i].kind, 16'h0, 16'h0, directed_rows[i].err);
      ev.run_last = 1'b1;
      send_byte(directed_rows[i].fbyte, directed_rows[i].fend, directed_rows[i].typed, ev);
      if (directed_rows[i].fend) begin
        frames_sent++;
      end
    end
    settle();

    for (int p = 0; p < N_RANDOM_PHASES; p++) begin
      s  = 8'($urandom);
      st = 16'($urandom);
      q  = 7'($urandom_range(1, 8));
      case (p)
        0: begin s = 8'h00; st = 16'hFFFE; q = 7'd3; end
        1: begin s = 8'hFF; st = 16'hFFFF; q = 7'd127; end
        2: q = 7'd0;
        3: begin s = 8'h01; st = 16'h0000; q = 7'd1; end
        4: q = 7'd125;
        default: ;
      endcase
      program_regs(s, st, q);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_frame();
      settle();
    end

    guard = 0;
    while (expected_events.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (expected_events.size() != 0) begin
      errors++;
      $display("%0t: %0d expected events never arrived", $time, expected_events.size());
    end

    $display("covered %0d bytes in %0d frames over %0d register settings", bytes_sent,
             frames_sent, settings_used);
    $display("checked %0d events, %0d of them register values", events_checked,
             values_checked);
    if (errors == 0) begin
      $display("rw_registers_response_parser_core verification clean");
    end else begin
      $display("rw_registers_response_parser_core verification failed");
    end
    $finish;
  end

endmodule
